@@ sv/dkp_pkg.sv @@
// Shared types, register indexes, reset values and helper functions of the keypad block.
package dkp_pkg;

    // Number of keys scanned each tick: power, down, ok, up.
    localparam int NumKeys = 4;
    localparam int KeyW    = 2;

    // Key positions within a tick.
    localparam logic [KeyW-1:0] KEY_POWER = 2'd0;
    localparam logic [KeyW-1:0] KEY_DOWN  = 2'd1;
    localparam logic [KeyW-1:0] KEY_OK    = 2'd2;
    localparam logic [KeyW-1:0] KEY_UP    = 2'd3;

    // Configuration register indexes.
    localparam logic [2:0] REG_REPEAT_PERIOD = 3'd0;
    localparam logic [2:0] REG_HOLD_DELAY    = 3'd1;
    localparam logic [2:0] REG_MENU_HOLD     = 3'd2;
    localparam logic [2:0] REG_STEP_SMALL    = 3'd3;
    localparam logic [2:0] REG_STEP_MEDIUM   = 3'd4;
    localparam logic [2:0] REG_STEP_LARGE    = 3'd5;
    localparam logic [2:0] REG_SETPOINT_MAX  = 3'd6;

    // Register reset values.
    localparam logic [7:0]  RST_REPEAT_PERIOD = 8'd3;
    localparam logic [15:0] RST_HOLD_DELAY    = 16'd150;
    localparam logic [15:0] RST_MENU_HOLD     = 16'd10000;
    localparam logic [9:0]  RST_STEP_SMALL    = 10'd10;
    localparam logic [9:0]  RST_STEP_MEDIUM   = 10'd50;
    localparam logic [9:0]  RST_STEP_LARGE    = 10'd100;
    localparam logic [9:0]  RST_SETPOINT_MAX  = 10'd1023;

    // Control modes.
    localparam logic [1:0] MODE_KEYS = 2'd0;

    // Menu cursor codes.
    localparam logic signed [2:0] CUR_NONE   = -3'sd1;
    localparam logic signed [2:0] CUR_FIRST  = 3'sd0;
    localparam logic signed [2:0] CUR_ESCAPE = 3'sd3;

    // Result of one setpoint change.
    typedef struct packed {
        logic       send;
        logic [9:0] value;
    } t_sp_change;

    // Move the setpoint by a signed step and clamp it to zero and the maximum.
    function automatic t_sp_change sp_change(input logic [9:0] sp, input logic [9:0] step,
                                             input logic neg, input logic [9:0] sp_max,
                                             input logic enable);
        logic signed [11:0] sum;
        t_sp_change         res;
        sum = neg ? $signed({2'b00, sp}) - $signed({2'b00, step})
                  : $signed({2'b00, sp}) + $signed({2'b00, step});
        res.send  = 1'b0;
        res.value = sp;
        if (enable) begin
            if (sum < 0) begin
                res.value = 10'd0;
                res.send  = 1'b1;
            end else if (sum[10:0] > {1'b0, sp_max}) begin
                res.value = sp_max;
            end else begin
                res.value = sum[9:0];
                res.send  = 1'b1;
            end
        end
        return res;
    endfunction

    // Move the menu cursor by one and clamp it to the range of picks and escape.
    function automatic logic signed [2:0] cursor_move(input logic signed [2:0] cur,
                                                      input logic up);
        logic signed [3:0] c;
        c = {cur[2], cur};
        if (up) begin
            if (c < 0) begin
                c = 4'sd0;
            end
            c = c + 4'sd1;
        end else begin
            c = c - 4'sd1;
        end
        if (c < 0) begin
            c = 4'sd0;
        end
        if (c > 4'sd3) begin
            c = 4'sd3;
        end
        return c[2:0];
    endfunction

endpackage

@@ sv/dkp_debounce.sv @@
// Per-key sample history and debounced level of the keypad block.
module dkp_debounce
    import dkp_pkg::*;
#(
    parameter int DEBOUNCE_LEN = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_sample,
    input  logic [NumKeys-1:0]  i_raw,
    output logic [NumKeys-1:0]  o_level
);

    logic [DEBOUNCE_LEN-1:0] r_hist  [NumKeys];
    logic [NumKeys-1:0]      r_level;

    // Shift in one sample per key and change the level only when all samples agree.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NumKeys; k++) begin
                r_hist[k] <= '1;
            end
            r_level <= '1;
        end else if (i_sample) begin
            for (int k = 0; k < NumKeys; k++) begin
                r_hist[k] <= {r_hist[k][DEBOUNCE_LEN-2:0], i_raw[k]};
                if ({r_hist[k][DEBOUNCE_LEN-2:0], i_raw[k]} == '0) begin
                    r_level[k] <= 1'b0;
                end else if ({r_hist[k][DEBOUNCE_LEN-2:0], i_raw[k]} == '1) begin
                    r_level[k] <= 1'b1;
                end
            end
        end
    end

    assign o_level = r_level;

endmodule

@@ sv/dkp_rem.sv @@
// Bit-serial remainder unit: dividend modulo an 8-bit nonzero divisor, one bit per cycle.
module dkp_rem #(
    parameter int CW = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [CW-1:0] i_dividend,
    input  logic [7:0]    i_divisor,
    output logic          o_done,
    output logic [7:0]    o_rem
);

    localparam int CntW = $clog2(CW + 1);

    logic [CW-1:0]   r_q;
    logic [7:0]      r_rem;
    logic [7:0]      r_div;
    logic [CntW-1:0] r_cnt;
    logic            r_done;
    logic [8:0]      w_trial;

    assign w_trial = {r_rem, r_q[CW-1]};

    // Restoring remainder step: shift in the next dividend bit and subtract if it fits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= CntW'(CW);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CntW'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_cnt != '0) begin
            r_q <= {r_q[CW-2:0], 1'b0};
            if (w_trial >= {1'b0, r_div}) begin
                r_rem <= 8'(w_trial - {1'b0, r_div});
            end else begin
                r_rem <= w_trial[7:0];
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

@@ sv/debounced_keypad_setpoint_adjust_top.sv @@
// Top level of the keypad block: configuration, key sequencer and result register.
// A held key passes through the edge, start, remainder, hold and output states, a released
// key through the edge and output states; a scan item also waits on output stalls and on the
// shared bit-serial remainder unit that checks the repeat phase for every held key.
// Throughput: one item per finished scan; the input is stalled while keys are handled.
// Reset is synchronous and active low; it restores all key state and register defaults.
module debounced_keypad_setpoint_adjust_top
    import dkp_pkg::*;
#(
    parameter int DEBOUNCE_LEN = 8,
    parameter int COUNT_WIDTH  = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [3:0]        i_raw_keys,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [1:0]        o_key_index,
    output logic              o_last_of_tick,
    output logic              o_send_setpoint,
    output logic [9:0]        o_setpoint,
    output logic              o_send_mode,
    output logic [1:0]        o_control_mode,
    output logic              o_save_request,
    output logic              o_power_on,
    output logic              o_power_off,
    output logic              o_adjust_enabled,
    output logic              o_menu_active,
    output logic signed [2:0] o_cursor,
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_idx,
    input  logic [15:0]       i_cfg_data
);

    localparam int CW = COUNT_WIDTH;

    // Sequencer states.
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EDGE  = 3'd1;
    localparam logic [2:0] S_START = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_HOLD  = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    // Configuration registers.
    logic [7:0]  r_repeat_period;
    logic [15:0] r_hold_delay;
    logic [15:0] r_menu_hold;
    logic [9:0]  r_step_small;
    logic [9:0]  r_step_medium;
    logic [9:0]  r_step_large;
    logic [9:0]  r_setpoint_max;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_repeat_period <= RST_REPEAT_PERIOD;
            r_hold_delay    <= RST_HOLD_DELAY;
            r_menu_hold     <= RST_MENU_HOLD;
            r_step_small    <= RST_STEP_SMALL;
            r_step_medium   <= RST_STEP_MEDIUM;
            r_step_large    <= RST_STEP_LARGE;
            r_setpoint_max  <= RST_SETPOINT_MAX;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_REPEAT_PERIOD: r_repeat_period <= i_cfg_data[7:0];
                REG_HOLD_DELAY:    r_hold_delay    <= i_cfg_data;
                REG_MENU_HOLD:     r_menu_hold     <= i_cfg_data;
                REG_STEP_SMALL:    r_step_small    <= i_cfg_data[9:0];
                REG_STEP_MEDIUM:   r_step_medium   <= i_cfg_data[9:0];
                REG_STEP_LARGE:    r_step_large    <= i_cfg_data[9:0];
                REG_SETPOINT_MAX:  r_setpoint_max  <= i_cfg_data[9:0];
                default: ;
            endcase
        end
    end

    // Sequencer and key state.
    logic [2:0]        r_state;
    logic [KeyW-1:0]   r_key;
    logic [NumKeys-1:0] r_press_seen;
    logic [CW-1:0]     r_hold [NumKeys];
    logic [CW-1:0]     r_t;
    logic              r_tge;
    logic [9:0]        r_setpoint;
    logic              r_adjust;
    logic              r_menu;
    logic signed [2:0] r_cursor;
    logic [1:0]        r_mode;
    logic              r_running;
    logic              r_ev_sp;
    logic              r_ev_mode;
    logic              r_ev_save;
    logic              r_ev_on;
    logic              r_ev_off;

    // Result register.
    logic              r_out_valid;
    logic [1:0]        r_o_key;
    logic              r_o_last;
    logic              r_o_sp_send;
    logic [9:0]        r_o_sp;
    logic              r_o_mode_send;
    logic [1:0]        r_o_mode;
    logic              r_o_save;
    logic              r_o_on;
    logic              r_o_off;
    logic              r_o_adjust;
    logic              r_o_menu;
    logic signed [2:0] r_o_cursor;

    logic              w_accept;
    logic [NumKeys-1:0] w_level;
    logic              w_rem_done;
    logic [7:0]        w_rem;
    logic [7:0]        w_per;
    logic [CW-1:0]     w_hold_cur;
    logic [CW-1:0]     w_t;
    logic              w_pressed;
    logic              w_first;
    logic              w_out_free;

    assign w_accept   = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign w_per      = (r_repeat_period == 8'd0) ? 8'd1 : r_repeat_period;
    assign w_hold_cur = r_hold[r_key];
    assign w_t        = w_hold_cur - CW'(r_hold_delay);
    assign w_pressed  = !w_level[r_key];
    assign w_first    = w_pressed && !r_press_seen[r_key];
    assign w_out_free = !r_out_valid || !i_out_stall;

    dkp_debounce #(
        .DEBOUNCE_LEN(DEBOUNCE_LEN)
    ) u_debounce (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sample(w_accept),
        .i_raw   (i_raw_keys),
        .o_level (w_level)
    );

    dkp_rem #(
        .CW(CW)
    ) u_rem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (r_state == S_START),
        .i_dividend(w_t),
        .i_divisor (w_per),
        .o_done    (w_rem_done),
        .o_rem     (w_rem)
    );

    // Press edge actions of the current key.
    t_sp_change        n_edge_sp;
    logic              n_e_sp;
    logic              n_e_mode;
    logic              n_e_save;
    logic              n_e_on;
    logic              n_e_off;
    logic [9:0]        n_sp_e;
    logic              n_adjust_e;
    logic              n_menu_e;
    logic signed [2:0] n_cursor_e;
    logic [1:0]        n_mode_e;
    logic              n_running_e;

    always_comb begin
        n_e_sp      = 1'b0;
        n_e_mode    = 1'b0;
        n_e_save    = 1'b0;
        n_e_on      = 1'b0;
        n_e_off     = 1'b0;
        n_sp_e      = r_setpoint;
        n_adjust_e  = r_adjust;
        n_menu_e    = r_menu;
        n_cursor_e  = r_cursor;
        n_mode_e    = r_mode;
        n_running_e = r_running;
        n_edge_sp   = sp_change(r_setpoint, 10'd1, (r_key == KEY_DOWN), r_setpoint_max,
                                r_adjust);
        case (r_key)
            KEY_POWER: begin
                n_running_e = !r_running;
                n_e_on      = !r_running;
                n_e_sp      = !r_running;
                n_e_off     = r_running;
            end
            KEY_DOWN, KEY_UP: begin
                if (r_menu) begin
                    n_cursor_e = cursor_move(r_cursor, (r_key == KEY_UP));
                end else begin
                    n_sp_e = n_edge_sp.value;
                    n_e_sp = n_edge_sp.send;
                end
            end
            default: begin
                if (r_menu) begin
                    if (r_cursor >= CUR_FIRST) begin
                        if (r_cursor != CUR_ESCAPE) begin
                            n_mode_e = r_cursor[1:0];
                            n_e_save = 1'b1;
                        end
                        n_menu_e   = 1'b0;
                        n_cursor_e = CUR_FIRST;
                        n_e_mode   = 1'b1;
                    end
                end else if (r_mode == MODE_KEYS) begin
                    n_e_save   = r_adjust;
                    n_adjust_e = !r_adjust;
                end
            end
        endcase
    end

    // Hold actions: repeat steps for up and down, menu opening for ok.
    logic [11:0]  w_lim15;
    logic [13:0]  w_lim50;
    logic [9:0]   w_step;
    t_sp_change   n_hold_sp;

    assign w_lim15 = ({4'b0, w_per} << 4) - {4'b0, w_per};
    assign w_lim50 = ({6'b0, w_per} << 5) + ({6'b0, w_per} << 4) + ({6'b0, w_per} << 1);

    always_comb begin
        if (r_t < CW'(w_lim15)) begin
            w_step = r_step_small;
        end else if (r_t < CW'(w_lim50)) begin
            w_step = r_step_medium;
        end else begin
            w_step = r_step_large;
        end
        n_hold_sp = sp_change(r_setpoint, w_step, (r_key == KEY_DOWN), r_setpoint_max,
                              r_adjust);
    end

    // Key sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_key        <= '0;
            r_press_seen <= '0;
            for (int k = 0; k < NumKeys; k++) begin
                r_hold[k] <= '0;
            end
            r_setpoint   <= '0;
            r_adjust     <= 1'b0;
            r_menu       <= 1'b0;
            r_cursor     <= CUR_FIRST;
            r_mode       <= MODE_KEYS;
            r_running    <= 1'b0;
            r_ev_sp      <= 1'b0;
            r_ev_mode    <= 1'b0;
            r_ev_save    <= 1'b0;
            r_ev_on      <= 1'b0;
            r_ev_off     <= 1'b0;
            r_t          <= '0;
            r_tge        <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        if (r_mode != MODE_KEYS) begin
                            r_adjust <= 1'b0;
                        end
                        r_key   <= '0;
                        r_state <= S_EDGE;
                    end
                end
                S_EDGE: begin
                    r_ev_sp   <= 1'b0;
                    r_ev_mode <= 1'b0;
                    r_ev_save <= 1'b0;
                    r_ev_on   <= 1'b0;
                    r_ev_off  <= 1'b0;
                    if (w_pressed) begin
                        if (w_first) begin
                            r_press_seen[r_key] <= 1'b1;
                            r_ev_sp    <= n_e_sp;
                            r_ev_mode  <= n_e_mode;
                            r_ev_save  <= n_e_save;
                            r_ev_on    <= n_e_on;
                            r_ev_off   <= n_e_off;
                            r_setpoint <= n_sp_e;
                            r_adjust   <= n_adjust_e;
                            r_menu     <= n_menu_e;
                            r_cursor   <= n_cursor_e;
                            r_mode     <= n_mode_e;
                            r_running  <= n_running_e;
                        end
                        if (w_hold_cur != '1) begin
                            r_hold[r_key] <= w_hold_cur + 1'b1;
                        end
                        r_state <= S_START;
                    end else begin
                        r_press_seen[r_key] <= 1'b0;
                        r_hold[r_key]       <= '0;
                        r_state             <= S_OUT;
                    end
                end
                S_START: begin
                    r_t     <= w_t;
                    r_tge   <= (w_hold_cur >= CW'(r_hold_delay));
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (w_rem_done) begin
                        r_state <= S_HOLD;
                    end
                end
                S_HOLD: begin
                    if (r_tge) begin
                        if (r_key == KEY_OK) begin
                            if (r_t > CW'(r_menu_hold) && !r_menu) begin
                                r_menu   <= 1'b1;
                                r_cursor <= CUR_NONE;
                            end
                        end else if (r_key != KEY_POWER && w_rem == 8'd0 && !r_menu) begin
                            r_setpoint <= n_hold_sp.value;
                            r_ev_sp    <= r_ev_sp | n_hold_sp.send;
                        end
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_key   <= r_key + 1'b1;
                        r_state <= (r_key == KEY_UP) ? S_IDLE : S_EDGE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Result register: loaded once per key, emptied by a transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_OUT && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && w_out_free) begin
            r_o_key       <= r_key;
            r_o_last      <= (r_key == KEY_UP);
            r_o_sp_send   <= r_ev_sp;
            r_o_sp        <= r_setpoint;
            r_o_mode_send <= r_ev_mode;
            r_o_mode      <= r_mode;
            r_o_save      <= r_ev_save;
            r_o_on        <= r_ev_on;
            r_o_off       <= r_ev_off;
            r_o_adjust    <= r_adjust;
            r_o_menu      <= r_menu;
            r_o_cursor    <= r_cursor;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_key_index      = r_o_key;
    assign o_last_of_tick   = r_o_last;
    assign o_send_setpoint  = r_o_sp_send;
    assign o_setpoint       = r_o_sp;
    assign o_send_mode      = r_o_mode_send;
    assign o_control_mode   = r_o_mode;
    assign o_save_request   = r_o_save;
    assign o_power_on       = r_o_on;
    assign o_power_off      = r_o_off;
    assign o_adjust_enabled = r_o_adjust;
    assign o_menu_active    = r_o_menu;
    assign o_cursor         = r_o_cursor;

`ifndef NO_ASSERTIONS
    // The last key of a tick is always flagged as such.
    a_last_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_key_index == KEY_UP |-> o_last_of_tick)
        else $error("last key of a tick not flagged");

    // The power key never starts and stops the unit in one result.
    a_power_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_power_on && o_power_off))
        else $error("power on and off together");

    // With the menu closed the cursor rests at the first entry.
    a_cursor_rest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_menu_active |-> o_cursor == CUR_FIRST)
        else $error("cursor moved with menu closed");

    // The remainder step never starts while another scan item is being taken.
    a_busy_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIV |-> o_in_stall)
        else $error("input open during remainder step");
`endif

endmodule
